>>> hdl/i2cwr_pkg.sv
// ----------------------------------------------------------------------------
// i2cwr_pkg: shared types and constants of the I2C write/read sequencer
// Command and ACK codes, transaction phases, sequencer state and result record.
// ----------------------------------------------------------------------------
package i2cwr_pkg;

  // Longest write or read run; longer counts saturate here.
  localparam logic [7:0] MaxLen = 8'd255;

  // Byte sent while the repeated start is being arranged.
  localparam logic [7:0] DummyByte = 8'hFF;

  // Request codes on the cmd field.
  localparam logic [2:0] CMD_BEGIN      = 3'd0;
  localparam logic [2:0] CMD_START_SENT = 3'd1;
  localparam logic [2:0] CMD_ADDR_ACKED = 3'd2;
  localparam logic [2:0] CMD_TX_EMPTY   = 3'd3;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd4;

  // ACK control codes.
  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CMD     = 3'd1,
    PH_START   = 3'd2,
    PH_WRITE   = 3'd3,
    PH_RESTART = 3'd4,
    PH_READ    = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] slave_address;
    logic [7:0] write_remaining;
    logic [7:0] read_remaining;
  } state_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] data_out;
    logic       write_taken;
    logic       start_request;
    logic       stop_request;
    logic [1:0] ack_control;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       idle;
  } res_t;

  function automatic logic [7:0] clip_len(input logic [7:0] v);
    return (v > MaxLen) ? MaxLen : v;
  endfunction

endpackage

>>> hdl/i2cwr_step.sv
// ----------------------------------------------------------------------------
// i2cwr_step: per-request update of the sequencer
// Works out the next state and the result record for one request.
// ----------------------------------------------------------------------------
module i2cwr_step (
  input  logic [2:0]       cmd,
  input  logic [6:0]       target_address,
  input  logic [7:0]       bytes_to_write,
  input  logic [7:0]       bytes_to_read,
  input  logic [7:0]       data_in,
  input  i2cwr_pkg::state_t state,
  output i2cwr_pkg::state_t state_nxt,
  output i2cwr_pkg::res_t   res
);
  import i2cwr_pkg::*;

  logic [7:0] rd_len;
  logic [7:0] rd_left;

  assign rd_len  = clip_len(bytes_to_read);
  assign rd_left = state.read_remaining - 8'd1;

  always_comb begin
    state_nxt = state;
    res       = '0;
    case (cmd)
      CMD_BEGIN: begin
        // a begin while busy restarts the transaction
        state_nxt.slave_address   = target_address;
        state_nxt.write_remaining = clip_len(bytes_to_write);
        state_nxt.read_remaining  = rd_len;
        state_nxt.phase           = PH_CMD;
        res.ack_control           = (rd_len == 8'd1) ? ACK_DISABLE : ACK_ENABLE;
        res.start_request         = 1'b1;
      end
      CMD_START_SENT: begin
        if (state.phase == PH_CMD) begin
          state_nxt.phase = PH_START;
          res.load_data   = 1'b1;
          res.data_out    = {state.slave_address, 1'b0};
        end else if (state.phase == PH_WRITE) begin
          state_nxt.phase = PH_RESTART;
          res.load_data   = 1'b1;
          res.data_out    = {state.slave_address, 1'b1};
        end
      end
      CMD_ADDR_ACKED: begin
        if (state.phase == PH_START) begin
          state_nxt.phase = PH_WRITE;
        end else if (state.phase == PH_RESTART) begin
          state_nxt.phase = PH_READ;
        end
      end
      CMD_TX_EMPTY: begin
        if (state.phase == PH_WRITE) begin
          if (state.write_remaining != 8'd0) begin
            state_nxt.write_remaining = state.write_remaining - 8'd1;
            res.load_data   = 1'b1;
            res.data_out    = data_in;
            res.write_taken = 1'b1;
          end else if (state.read_remaining != 8'd0) begin
            // asks again on every empty event until the start goes out
            res.start_request = 1'b1;
            res.load_data     = 1'b1;
            res.data_out      = DummyByte;
          end else begin
            res.stop_request = 1'b1;
            state_nxt.phase  = PH_IDLE;
          end
        end
      end
      CMD_RX_BYTE: begin
        if (state.phase == PH_READ && state.read_remaining != 8'd0) begin
          state_nxt.read_remaining = rd_left;
          if (rd_left == 8'd1) begin
            res.ack_control = ACK_DISABLE;
          end else if (rd_left == 8'd0) begin
            res.stop_request = 1'b1;
            state_nxt.phase  = PH_IDLE;
          end
          res.read_valid = 1'b1;
          res.read_byte  = data_in;
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
    res.idle = (state_nxt.phase == PH_IDLE);
  end

endmodule

>>> hdl/i2cwr_outbuf.sv
// ----------------------------------------------------------------------------
// i2cwr_outbuf: two-entry result buffer
// Output register plus skid entry; takes a new result while one waits.
// ----------------------------------------------------------------------------
module i2cwr_outbuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_stall,
  input  i2cwr_pkg::res_t push_res,
  output logic            pop_valid,
  input  logic            pop_stall,
  output i2cwr_pkg::res_t pop_res
);
  import i2cwr_pkg::*;

  logic main_valid_r;
  logic skid_valid_r;
  res_t main_res_r;
  res_t skid_res_r;
  logic push;
  logic pop;

  assign push_stall = skid_valid_r;
  assign push       = push_valid & ~skid_valid_r;
  assign pop        = main_valid_r & ~pop_stall;
  assign pop_valid  = main_valid_r;
  assign pop_res    = main_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_res_r   <= skid_res_r;
        skid_valid_r <= 1'b0;   // no push while skid is full
      end else begin
        main_valid_r <= push;
        if (push) begin
          main_res_r <= push_res;
        end
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_r <= 1'b1;
        skid_res_r   <= push_res;
      end else begin
        main_valid_r <= 1'b1;
        main_res_r   <= push_res;
      end
    end
  end

endmodule

>>> hdl/i2c_master_write_read_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer: I2C master combined write/read sequencer
// Requests on the in_ channel are a begin command or a byte-engine event
// (start sent, address acked, transmit empty, byte received). Each request
// yields exactly one result on the out_ channel: byte to load, start/stop
// requests, ACK control, received byte and an idle flag.
// The result of a taken request is registered in the result buffer before out_valid shows it.
// Throughput: one request per cycle while in_stall is low; the state update is a single pass
// through the step logic between the state registers and the output register.
// Reset (rst_n low, synchronous): phase goes idle, address and counters clear,
// the result buffer empties and in_stall drops.
// Stall: results sit in a two-entry buffer; with out_stall high one further
// request is still taken, then in_stall rises until out_stall releases.
// ----------------------------------------------------------------------------
module i2c_master_write_read_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_bytes_to_write,
  input  logic [7:0] in_bytes_to_read,
  input  logic [7:0] in_data_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_load_data,
  output logic [7:0] out_data_out,
  output logic       out_write_taken,
  output logic       out_start_request,
  output logic       out_stop_request,
  output logic [1:0] out_ack_control,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_idle
);
  import i2cwr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  res_t   step_res;
  res_t   out_res;
  logic   accept;

  assign accept = in_valid & ~in_stall;

  // Next state and result for the request on the input ports.
  i2cwr_step u_step (
    .cmd            (in_cmd),
    .target_address (in_target_address),
    .bytes_to_write (in_bytes_to_write),
    .bytes_to_read  (in_bytes_to_read),
    .data_in        (in_data_in),
    .state          (state_r),
    .state_nxt      (state_nxt),
    .res            (step_res)
  );

  // State moves only when a request is actually taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase           <= PH_IDLE;
      state_r.slave_address   <= '0;
      state_r.write_remaining <= '0;
      state_r.read_remaining  <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register with skid entry; in_stall comes straight from a flop.
  i2cwr_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_res   (step_res),
    .pop_valid  (out_valid),
    .pop_stall  (out_stall),
    .pop_res    (out_res)
  );

  assign out_load_data     = out_res.load_data;
  assign out_data_out      = out_res.data_out;
  assign out_write_taken   = out_res.write_taken;
  assign out_start_request = out_res.start_request;
  assign out_stop_request  = out_res.stop_request;
  assign out_ack_control   = out_res.ack_control;
  assign out_read_valid    = out_res.read_valid;
  assign out_read_byte     = out_res.read_byte;
  assign out_idle          = out_res.idle;

endmodule

>>> hdl/i2cwr_checker.sv
// ----------------------------------------------------------------------------
// i2cwr_checker: port-level checks of the write/read sequencer
// Bound to the top level; watches the request and result channels only.
// ----------------------------------------------------------------------------
module i2cwr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_load_data,
  input logic [7:0] out_data_out,
  input logic       out_write_taken,
  input logic       out_stop_request,
  input logic       out_read_valid,
  input logic       out_idle
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_out)
      && $stable(out_load_data))
    else $error("stalled result changed");

  // a stop always ends the transaction
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_request |-> out_idle)
    else $error("stop without idle");

  // a consumed write byte is always loaded, never alongside a read byte
  a_taken_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_taken |-> out_load_data && !out_read_valid)
    else $error("write byte taken but not loaded");

  // buffer comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule

bind i2c_master_write_read_sequencer i2cwr_checker u_i2cwr_checker (.*);

>>> verif/i2c_master_write_read_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer_tb: self-checking bench for the sequencer
// A queue of requests (directed corner cases, then mostly well-formed
// write/read transactions with some noise) feeds a clocked driver. A local
// model of the sequencer predicts one result per accepted request, and a
// clocked monitor checks every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_write_read_sequencer_tb;
  import i2cwr_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomTarget = 600;
  // Result count at which the receiver holds off for a long stretch.
  localparam int HoldAt       = 450;
  localparam int HoldCycles   = 40;

  // One request as the host would present it.
  typedef struct {
    logic [2:0] cmd;
    logic [6:0] addr;
    logic [7:0] n_write;
    logic [7:0] n_read;
    logic [7:0] data;
  } i2c_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_cmd = '0;
  logic [6:0] in_target_address = '0;
  logic [7:0] in_bytes_to_write = '0;
  logic [7:0] in_bytes_to_read = '0;
  logic [7:0] in_data_in = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_load_data;
  logic [7:0] out_data_out;
  logic       out_write_taken;
  logic       out_start_request;
  logic       out_stop_request;
  logic [1:0] out_ack_control;
  logic       out_read_valid;
  logic [7:0] out_read_byte;
  logic       out_idle;

  i2c_req_t pending_reqs[$];
  res_t     expected_results[$];
  i2c_req_t req_on_bus;

  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Local copy of the sequencer state.
  phase_t     seq_phase   = PH_IDLE;
  logic [6:0] seq_addr    = '0;
  logic [7:0] seq_wr_left = '0;
  logic [7:0] seq_rd_left = '0;

  i2c_master_write_read_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_target_address (in_target_address),
    .in_bytes_to_write (in_bytes_to_write),
    .in_bytes_to_read  (in_bytes_to_read),
    .in_data_in        (in_data_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_load_data     (out_load_data),
    .out_data_out      (out_data_out),
    .out_write_taken   (out_write_taken),
    .out_start_request (out_start_request),
    .out_stop_request  (out_stop_request),
    .out_ack_control   (out_ack_control),
    .out_read_valid    (out_read_valid),
    .out_read_byte     (out_read_byte),
    .out_idle          (out_idle)
  );

  // --------------------------------------------------------------------------
  // Sequencer model: advances the local state by one request and returns
  // the result the block should give for it.
  // --------------------------------------------------------------------------
  function automatic res_t sequence_step(input i2c_req_t r);
    res_t e;
    e = '0;
    case (r.cmd)
      CMD_BEGIN: begin
        // a begin always restarts, even mid-transaction
        seq_addr    = r.addr;
        seq_wr_left = (r.n_write > MaxLen) ? MaxLen : r.n_write;
        seq_rd_left = (r.n_read > MaxLen) ? MaxLen : r.n_read;
        seq_phase   = PH_CMD;
        e.ack_control   = (seq_rd_left == 8'd1) ? ACK_DISABLE : ACK_ENABLE;
        e.start_request = 1'b1;
      end
      CMD_START_SENT: begin
        if (seq_phase == PH_CMD) begin
          seq_phase   = PH_START;
          e.load_data = 1'b1;
          e.data_out  = {seq_addr, 1'b0};
        end else if (seq_phase == PH_WRITE) begin
          // repeated start: address with the read bit
          seq_phase   = PH_RESTART;
          e.load_data = 1'b1;
          e.data_out  = {seq_addr, 1'b1};
        end
      end
      CMD_ADDR_ACKED: begin
        if (seq_phase == PH_START) seq_phase = PH_WRITE;
        else if (seq_phase == PH_RESTART) seq_phase = PH_READ;
      end
      CMD_TX_EMPTY: begin
        if (seq_phase == PH_WRITE) begin
          if (seq_wr_left != 8'd0) begin
            seq_wr_left     = seq_wr_left - 8'd1;
            e.load_data     = 1'b1;
            e.data_out      = r.data;
            e.write_taken   = 1'b1;
          end else if (seq_rd_left != 8'd0) begin
            // asks again for the repeated start on every such event
            e.start_request = 1'b1;
            e.load_data     = 1'b1;
            e.data_out      = DummyByte;
          end else begin
            e.stop_request  = 1'b1;
            seq_phase       = PH_IDLE;
          end
        end
      end
      CMD_RX_BYTE: begin
        // nothing left to read: ignored, counter stays at zero
        if (seq_phase == PH_READ && seq_rd_left != 8'd0) begin
          seq_rd_left = seq_rd_left - 8'd1;
          if (seq_rd_left == 8'd1) begin
            e.ack_control = ACK_DISABLE;  // NACK ahead of the last byte
          end else if (seq_rd_left == 8'd0) begin
            e.stop_request = 1'b1;
            seq_phase      = PH_IDLE;
          end
          e.read_valid = 1'b1;
          e.read_byte  = r.data;
        end
      end
      default: ;  // unused codes do nothing
    endcase
    e.idle = (seq_phase == PH_IDLE);
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_req(input logic [2:0] cmd, input logic [6:0] addr,
                                    input logic [7:0] n_write, input logic [7:0] n_read,
                                    input logic [7:0] data);
    i2c_req_t r;
    r.cmd = cmd;
    r.addr = addr;
    r.n_write = n_write;
    r.n_read = n_read;
    r.data = data;
    pending_reqs.push_back(r);
  endfunction

  // An engine event with random filler; now and then a stray request after it.
  function automatic void queue_event(input logic [2:0] cmd);
    queue_req(cmd, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < 5)
      queue_req(3'($urandom_range(0, 7)), 7'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
  endfunction

  // A whole write-then-read transaction with random content. Long counts
  // are cut short, so the next begin lands on a busy sequencer.
  function automatic void queue_transaction();
    int n_wr;
    int n_rd;
    if ($urandom_range(0, 15) == 0) begin
      n_wr = $urandom_range(0, 255);
      n_rd = $urandom_range(0, 255);
    end else begin
      n_wr = $urandom_range(0, 4);
      n_rd = $urandom_range(0, 4);
    end
    queue_req(CMD_BEGIN, 7'($urandom), 8'(n_wr), 8'(n_rd), 8'($urandom));
    queue_event(CMD_START_SENT);
    queue_event(CMD_ADDR_ACKED);
    for (int i = 0; i < n_wr && i < 6; i++) queue_event(CMD_TX_EMPTY);
    if (n_rd == 0) begin
      queue_event(CMD_TX_EMPTY);
    end else begin
      repeat ($urandom_range(1, 2)) queue_event(CMD_TX_EMPTY);
      queue_event(CMD_START_SENT);
      queue_event(CMD_ADDR_ACKED);
      for (int i = 0; i < n_rd && i < 6; i++) queue_event(CMD_RX_BYTE);
      if ($urandom_range(0, 3) == 0) queue_event(CMD_RX_BYTE);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: predicts on every accepted request, then offers the next one
  // unless the sender idles. Idling: 29 % for the first 200 requests, 49 %
  // for the next 200, none after that.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(sequence_step(req_on_bus));
        n_accepted++;
      end
      // a held request stays put until taken
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= ((n_accepted < 200) ? 29 :
                                      (n_accepted < 400) ? 49 : 0)) begin
          req_on_bus = pending_reqs.pop_front();
          in_valid          <= 1'b1;
          in_cmd            <= req_on_bus.cmd;
          in_target_address <= req_on_bus.addr;
          in_bytes_to_write <= req_on_bus.n_write;
          in_bytes_to_read  <= req_on_bus.n_read;
          in_data_in        <= req_on_bus.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result and drives out_stall. Stall rate
  // mirrors the driver's phases (49 %, then 29 %, then none); once, the
  // receiver holds off long enough for the block to back up its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending");
          n_errors++;
        end else begin
          res_t want;
          want = expected_results.pop_front();
          check_field("load_data", 8'(want.load_data), 8'(out_load_data));
          check_field("data_out", want.data_out, out_data_out);
          check_field("write_taken", 8'(want.write_taken), 8'(out_write_taken));
          check_field("start_request", 8'(want.start_request), 8'(out_start_request));
          check_field("stop_request", 8'(want.stop_request), 8'(out_stop_request));
          check_field("ack_control", 8'(want.ack_control), 8'(out_ack_control));
          check_field("read_valid", 8'(want.read_valid), 8'(out_read_valid));
          check_field("read_byte", want.read_byte, out_read_byte);
          check_field("idle", 8'(want.idle), 8'(out_idle));
        end
        n_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && n_checked >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < ((n_accepted < 200) ? 49 :
                                               (n_accepted < 400) ? 29 : 0));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request list and end of run
  // --------------------------------------------------------------------------
  initial begin
    // engine events and unused codes while idle: all ignored
    queue_req(CMD_START_SENT, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_ADDR_ACKED, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
    queue_req(CMD_TX_EMPTY, 7'h00, 8'h00, 8'h00, 8'hFF);
    queue_req(CMD_RX_BYTE, 7'h7F, 8'hFF, 8'hFF, 8'h00);
    for (int c = CMD_RX_BYTE + 1; c < 8; c++) queue_req(3'(c), 7'h55, 8'hAA, 8'h55, 8'hAA);
    // longest counts, then a begin while busy replaces them
    queue_req(CMD_BEGIN, 7'h7F, 8'hFF, 8'hFF, 8'h00);
    queue_req(CMD_BEGIN, 7'h7F, 8'd2, 8'd3, 8'h00);
    queue_req(CMD_START_SENT, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_ADDR_ACKED, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_TX_EMPTY, 7'h00, 8'h00, 8'h00, 8'hFF);
    queue_req(CMD_TX_EMPTY, 7'h00, 8'h00, 8'h00, 8'h00);
    // writes done, reads pending: dummy byte, asked for twice
    queue_req(CMD_TX_EMPTY, 7'h00, 8'h00, 8'h00, 8'h3C);
    queue_req(CMD_TX_EMPTY, 7'h00, 8'h00, 8'h00, 8'hC3);
    queue_req(CMD_START_SENT, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_ADDR_ACKED, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'hA5);
    queue_req(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'hFF);
    // nothing left to read
    queue_req(CMD_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h5A);
    // write-only, zero bytes: straight to stop
    queue_req(CMD_BEGIN, 7'h00, 8'd0, 8'd0, 8'hFF);
    queue_req(CMD_START_SENT, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_ADDR_ACKED, 7'h00, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_TX_EMPTY, 7'h00, 8'h00, 8'h00, 8'h00);

    while (pending_reqs.size() < RandomTarget + 25) queue_transaction();

    // drain: every request taken and every result seen
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
